FILE: src/ccrfr_pkg.sv
`default_nettype none

package ccrfr_pkg;

    // Highest frame byte index that is stored; the position counter stops one above it.
    localparam int MAX_POSITION = 63;
    localparam int POS_W        = $clog2(MAX_POSITION + 2);

    // Frame start pair and CRC-16/X-25 constants.
    localparam logic [7:0]  START_A  = 8'h5A;
    localparam logic [7:0]  START_B  = 8'h2C;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // Reply command codes.
    localparam logic [15:0] CMD_ENROL_ACK    = 16'h030A;
    localparam logic [15:0] CMD_ENROL_RESULT = 16'h030D;
    localparam logic [15:0] CMD_IDENT_ACK    = 16'h020A;
    localparam logic [15:0] CMD_IDENT_RESULT = 16'h020D;
    localparam logic [15:0] CMD_DELETE_ACK   = 16'h040A;
    localparam logic [15:0] CMD_STATUS_ACK   = 16'h0D0A;

    // Input operation codes.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Reflected CRC update over one byte, one bit per step.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    // CRC register after the first start byte has been fed.
    localparam logic [15:0] CRC_AFTER_START = crc_feed(CRC_INIT, START_A);

endpackage

`default_nettype wire

FILE: src/crc_checked_reply_frame_receiver.sv
`default_nettype none

// Frame receiver for a CRC-checked reply stream. Each input item is either one received
// serial byte (op 0) or a clear request (op 1) that drops the held reply flag and face id.
// The pair 0x5A 0x2C starts a frame at any time, bytes 4..5 carry the big-endian total
// length, bytes 6..7 the command, and the last two bytes a CRC-16/X-25 check word taken
// big-endian. Frames shorter than 10 bytes are dropped, and frames longer than the
// internal position limit never close. Exactly one result item follows every input item:
// the frame-end and CRC-good flags for that byte plus the held reply flag, face id and
// current command word. The byte-wide CRC update and all frame decoding sit in one
// combinational stage ahead of the result register, so an item is accepted every cycle
// while s_ready is high; its result appears in the next cycle. s_ready falls only while
// the result register is full and m_ready is low. No clearing pass is needed after reset.
module crc_checked_reply_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_frame_end,
    output logic             m_frame_good,
    output logic             m_reply_seen,
    output logic [15:0]      m_face_id,
    output logic [15:0]      m_reply_command
);
    import ccrfr_pkg::*;

    // Receive state.
    logic [7:0]       prev_byte_reg,   prev_byte_next;
    logic [POS_W-1:0] pos_reg,         pos_next;
    logic [15:0]      length_reg,      length_next;
    logic [15:0]      crc_reg,         crc_next;
    logic [15:0]      command_reg,     command_next;
    logic [7:0]       result_reg [4];
    logic [7:0]       result_next [4];
    logic [15:0]      check_reg,       check_next;
    logic             reply_flag_reg,  reply_flag_next;
    logic [15:0]      face_id_reg,     face_id_next;

    // Result register.
    logic             m_valid_reg;
    logic             out_end_reg,     out_end_next;
    logic             out_good_reg,    out_good_next;

    // Working values for one byte.
    logic             accept;
    logic             start_pair;
    logic [POS_W-1:0] pos_k;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      length_base;
    logic [15:0]      crc_base;
    logic             in_frame;
    logic             crc_byte;
    logic             crc_match;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Byte decode, CRC update and frame close.
    always_comb begin
        prev_byte_next  = prev_byte_reg;
        pos_next        = pos_reg;
        length_next     = length_reg;
        crc_next        = crc_reg;
        command_next    = command_reg;
        result_next     = result_reg;
        check_next      = check_reg;
        reply_flag_next = reply_flag_reg;
        face_id_next    = face_id_reg;
        out_end_next    = 1'b0;
        out_good_next   = 1'b0;
        crc_match       = 1'b0;

        start_pair  = (prev_byte_reg == START_A) && (s_rx_byte == START_B);
        pos_k       = start_pair ? POS_W'(1) : pos_reg;
        length_base = start_pair ? 16'h0000 : length_reg;
        crc_base    = start_pair ? CRC_AFTER_START : crc_reg;
        pos_inc     = pos_k + POS_W'(1);
        in_frame    = (pos_k >= POS_W'(1)) && (pos_k <= POS_W'(MAX_POSITION));
        crc_byte    = (pos_k < POS_W'(8)) ||
                      ((17'(pos_k) + 17'd2) < {1'b0, length_base});

        if (s_op == OP_CLEAR) begin
            reply_flag_next = 1'b0;
            face_id_next    = 16'h0000;
        end else begin
            prev_byte_next = s_rx_byte;
            length_next    = length_base;
            crc_next       = crc_base;
            pos_next       = pos_k;

            if (in_frame) begin
                // Header field capture.
                if (pos_k == POS_W'(4)) begin
                    length_next = {s_rx_byte, length_base[7:0]};
                end else if (pos_k == POS_W'(5)) begin
                    length_next = {length_base[15:8], s_rx_byte};
                end else if (pos_k == POS_W'(6)) begin
                    command_next = {s_rx_byte, command_reg[7:0]};
                end else if (pos_k == POS_W'(7)) begin
                    command_next = {command_reg[15:8], s_rx_byte};
                end
                for (int i = 0; i < 4; i++) begin
                    if (pos_k == POS_W'(16 + i)) begin
                        result_next[i] = s_rx_byte;
                    end
                end

                // Bytes ahead of the check word feed the CRC, the last two form the check word.
                if (crc_byte) begin
                    crc_next = crc_feed(crc_base, s_rx_byte);
                end else begin
                    check_next = {check_reg[7:0], s_rx_byte};
                end

                pos_next = pos_inc;

                if (pos_inc == POS_W'(8)) begin
                    // A length below the minimum frame is dropped here.
                    if (length_next < 16'd10) begin
                        length_next = 16'h0000;
                        pos_next    = '0;
                    end
                end else if ((pos_inc > POS_W'(8)) && (16'(pos_inc) >= length_next)) begin
                    out_end_next = 1'b1;
                    crc_match    = (~crc_next == check_next);
                    out_good_next = crc_match;
                    if (crc_match) begin
                        case (command_next) inside
                            CMD_ENROL_ACK, CMD_IDENT_ACK, CMD_DELETE_ACK, CMD_STATUS_ACK: begin
                                reply_flag_next = 1'b1;
                            end
                            CMD_ENROL_RESULT: begin
                                reply_flag_next = 1'b1;
                                face_id_next = (result_next[2] == 8'h00) ?
                                               {result_next[0], result_next[1]} : 16'h0000;
                            end
                            CMD_IDENT_RESULT: begin
                                reply_flag_next = 1'b1;
                                face_id_next = (result_next[3] == 8'h00) ?
                                               {result_next[1], result_next[2]} : 16'h0000;
                            end
                            default: begin
                            end
                        endcase
                    end
                    length_next = 16'h0000;
                    pos_next    = '0;
                end
            end
        end
    end

    // Receive state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_byte_reg  <= 8'h00;
            pos_reg        <= '0;
            length_reg     <= 16'h0000;
            crc_reg        <= CRC_INIT;
            command_reg    <= 16'h0000;
            result_reg     <= '{default: 8'h00};
            check_reg      <= 16'h0000;
            reply_flag_reg <= 1'b0;
            face_id_reg    <= 16'h0000;
        end else if (accept) begin
            prev_byte_reg  <= prev_byte_next;
            pos_reg        <= pos_next;
            length_reg     <= length_next;
            crc_reg        <= crc_next;
            command_reg    <= command_next;
            result_reg     <= result_next;
            check_reg      <= check_next;
            reply_flag_reg <= reply_flag_next;
            face_id_reg    <= face_id_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload; the held values are shown straight from the state registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_end_reg  <= out_end_next;
            out_good_reg <= out_good_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_end     = out_end_reg;
    assign m_frame_good    = out_good_reg;
    assign m_reply_seen    = reply_flag_reg;
    assign m_face_id       = face_id_reg;
    assign m_reply_command = command_reg;

endmodule

`default_nettype wire

FILE: src/ccrfr_checker.sv
`default_nettype none

module ccrfr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_op,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_frame_end,
    input wire logic        m_frame_good,
    input wire logic        m_reply_seen,
    input wire logic [15:0] m_face_id,
    input wire logic [15:0] m_reply_command
);
    import ccrfr_pkg::*;

    // Every accepted item produces a result in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item gave no result");

    // A clear request leaves the flag and id cleared and closes no frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_CLEAR) |=>
        m_valid && !m_reply_seen && (m_face_id == 16'h0000) && !m_frame_end)
        else $error("clear request did not clear held reply state");

    // A good CRC is only reported on a closing byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_good |-> m_frame_end)
        else $error("frame_good without frame_end");

    // A waiting result stays until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_end) && $stable(m_frame_good) &&
        $stable(m_reply_seen) && $stable(m_face_id) && $stable(m_reply_command))
        else $error("result dropped while stalled");

endmodule

bind crc_checked_reply_frame_receiver ccrfr_checker u_ccrfr_checker (.*);

`default_nettype wire

FILE: bench/reply_frame_checker.sv
// Watches both channels of the frame receiver, predicts the result of every
// accepted input item and compares it with the result items that come back.
module reply_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_frame_end,
    input  wire logic        m_frame_good,
    input  wire logic        m_reply_seen,
    input  wire logic [15:0] m_face_id,
    input  wire logic [15:0] m_reply_command,
    output int               fail_count,
    output int               results_owed
);

    import ccrfr_pkg::*;

    typedef struct packed {
        logic        frame_end;
        logic        frame_good;
        logic        reply_seen;
        logic [15:0] face_id;
        logic [15:0] reply_command;
    } rx_result_t;

    // Results predicted but not yet seen, oldest first.
    rx_result_t  owed_q[$];

    // Receiver state as the block ought to hold it.
    logic [7:0]  last_byte;
    int          next_pos;
    logic [15:0] frame_len;
    logic [15:0] crc_reg;
    logic [15:0] cmd_word;
    logic [7:0]  id_bytes [4];
    logic [15:0] check_bytes;
    logic        reply_flag_q;
    logic [15:0] face_id_q;

    initial fail_count = 0;

    // Reflected CRC-16 step over one byte, least significant bit first.
    function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        r = crc ^ {8'h00, data};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // Advance the predicted receiver by one item and return the result it should give.
    task automatic predict_item(input logic op, input logic [7:0] data, output rx_result_t res);
        int   k;
        logic ended;
        logic good;
        ended = 1'b0;
        good  = 1'b0;
        if (op == OP_CLEAR) begin
            reply_flag_q = 1'b0;
            face_id_q    = 16'h0000;
        end else begin
            // A start pair abandons whatever frame is open and restarts the CRC.
            if (last_byte == START_A && data == START_B) begin
                crc_reg   = x25_update(CRC_INIT, START_A);
                frame_len = 16'h0000;
                next_pos  = 1;
            end
            k = next_pos;
            if (k >= 1 && k <= MAX_POSITION) begin
                case (k)
                    4: frame_len[15:8] = data;
                    5: frame_len[7:0]  = data;
                    6: cmd_word[15:8]  = data;
                    7: cmd_word[7:0]   = data;
                    default: ;
                endcase
                if (k >= 16 && k <= 19) begin
                    id_bytes[k - 16] = data;
                end
                // Bytes ahead of the check word feed the CRC; the last two are collected.
                if (k < 8 || k + 2 < int'(frame_len)) begin
                    crc_reg = x25_update(crc_reg, data);
                end else begin
                    check_bytes = {check_bytes[7:0], data};
                end
                next_pos = k + 1;
                if (next_pos == 8) begin
                    // Lengths below the minimum frame are dropped silently.
                    if (frame_len < 16'd10) begin
                        frame_len = 16'h0000;
                        next_pos  = 0;
                    end
                end else if (next_pos > 8 && next_pos >= int'(frame_len)) begin
                    ended = 1'b1;
                    good  = ((~crc_reg) == check_bytes);
                    if (good) begin
                        case (cmd_word)
                            CMD_ENROL_ACK, CMD_IDENT_ACK, CMD_DELETE_ACK, CMD_STATUS_ACK: begin
                                reply_flag_q = 1'b1;
                            end
                            CMD_ENROL_RESULT: begin
                                reply_flag_q = 1'b1;
                                face_id_q = (id_bytes[2] == 8'h00) ?
                                            {id_bytes[0], id_bytes[1]} : 16'h0000;
                            end
                            CMD_IDENT_RESULT: begin
                                reply_flag_q = 1'b1;
                                face_id_q = (id_bytes[3] == 8'h00) ?
                                            {id_bytes[1], id_bytes[2]} : 16'h0000;
                            end
                            default: ;
                        endcase
                    end
                    frame_len = 16'h0000;
                    next_pos  = 0;
                end
            end
            last_byte = data;
        end
        res.frame_end     = ended;
        res.frame_good    = good;
        res.reply_seen    = reply_flag_q;
        res.face_id       = face_id_q;
        res.reply_command = cmd_word;
    endtask

    // Count and report one field that differs from its prediction.
    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    // Results are compared before the item accepted on the same edge is predicted,
    // since that item's result cannot appear before the next edge.
    always @(posedge aclk) begin : watch
        rx_result_t want;
        if (!aresetn) begin
            last_byte    = 8'h00;
            next_pos     = 0;
            frame_len    = 16'h0000;
            crc_reg      = CRC_INIT;
            cmd_word     = 16'h0000;
            id_bytes     = '{default: 8'h00};
            check_bytes  = 16'h0000;
            reply_flag_q = 1'b0;
            face_id_q    = 16'h0000;
            owed_q.delete();
            results_owed <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result item with nothing expected, got end %b good %b cmd %h",
                             $time, m_frame_end, m_frame_good, m_reply_command);
                end else begin
                    want = owed_q.pop_front();
                    check_field("frame_end", want.frame_end, m_frame_end);
                    check_field("frame_good", want.frame_good, m_frame_good);
                    check_field("reply_seen", want.reply_seen, m_reply_seen);
                    check_field("face_id", want.face_id, m_face_id);
                    check_field("reply_command", want.reply_command, m_reply_command);
                end
            end
            if (s_valid && s_ready) begin
                predict_item(s_op, s_rx_byte, want);
                owed_q.push_back(want);
            end
            results_owed <= owed_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
module tb_top;

    import ccrfr_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_BYTE;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_frame_end;
    logic        m_frame_good;
    logic        m_reply_seen;
    logic [15:0] m_face_id;
    logic [15:0] m_reply_command;

    int fail_count;
    int results_owed;
    int items_sent = 0;
    bit idle_on = 1'b1;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    crc_checked_reply_frame_receiver u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_end     (m_frame_end),
        .m_frame_good    (m_frame_good),
        .m_reply_seen    (m_reply_seen),
        .m_face_id       (m_face_id),
        .m_reply_command (m_reply_command)
    );

    reply_frame_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_end     (m_frame_end),
        .m_frame_good    (m_frame_good),
        .m_reply_seen    (m_reply_seen),
        .m_face_id       (m_face_id),
        .m_reply_command (m_reply_command),
        .fail_count      (fail_count),
        .results_owed    (results_owed)
    );

    // Hang guard, well beyond the slowest correct run.
    initial begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one item after a random gap and hold it until it is accepted.
    task automatic put_item(input logic op, input logic [7:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_rx_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // A reply command, weighted towards the two result replies.
    function automatic logic [15:0] any_reply_cmd();
        case ($urandom_range(0, 7))
            0: return CMD_ENROL_ACK;
            1: return CMD_IDENT_ACK;
            2: return CMD_DELETE_ACK;
            3: return CMD_STATUS_ACK;
            4, 5: return CMD_ENROL_RESULT;
            default: return CMD_IDENT_RESULT;
        endcase
    endfunction

    // Send the first 'count' bytes of a frame with total length 'len'. The check word
    // sits at len-2 and len-1; 'spoil' flips one bit after the command word.
    task automatic send_frame(input logic [15:0] cmd, input int len, input int count,
                              input bit spoil, input bit with_clears);
        logic [7:0]  fr [$];
        logic [15:0] crc;
        logic [15:0] len_word;
        logic [7:0]  b;
        int          flip;
        crc      = CRC_INIT;
        len_word = len[15:0];
        for (int i = 0; i < count; i++) begin
            case (i)
                0: b = START_A;
                1: b = START_B;
                4: b = len_word[15:8];
                5: b = len_word[7:0];
                6: b = cmd[15:8];
                7: b = cmd[7:0];
                default: begin
                    if (i == len - 2) begin
                        b = ~crc[15:8];
                    end else if (i == len - 1) begin
                        b = ~crc[7:0];
                    end else begin
                        b = 8'($urandom_range(0, 255));
                        // Status bytes of the result replies are often zero.
                        if ((i == 18 || i == 19) && $urandom_range(0, 1) == 1) begin
                            b = 8'h00;
                        end
                        // Keep the body from holding a start pair of its own.
                        if (fr[i - 1] == START_A && b == START_B) begin
                            b = 8'h2D;
                        end
                    end
                end
            endcase
            if (i < len - 2) begin
                crc ^= {8'h00, b};
                repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
            fr.push_back(b);
        end
        if (spoil && count >= 10) begin
            flip = $urandom_range(8, count - 1);
            fr[flip] ^= 8'h01 << $urandom_range(0, 7);
        end
        foreach (fr[i]) begin
            if (with_clears && $urandom_range(0, 31) == 0) begin
                put_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            end
            put_item(OP_BYTE, fr[i]);
        end
    endtask

    // The result side stalls for a random number of cycles before each item.
    initial begin : result_stall
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int          pick;
        int          len;
        logic [15:0] cmd;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Idle bytes at both extremes, and a clear with every data bit set.
        put_item(OP_BYTE, 8'h00);
        put_item(OP_BYTE, 8'hFF);
        put_item(OP_CLEAR, 8'hFF);
        // Shortest frame that closes, carrying a known acknowledge.
        send_frame(CMD_ENROL_ACK, 10, 10, 1'b0, 1'b0);
        // A zero length is dropped once the command word is in.
        send_frame(CMD_STATUS_ACK, 0, 8, 1'b0, 1'b0);
        put_item(OP_CLEAR, 8'h00);

        // Mostly well-formed frames with random content, plus broken ones and noise.
        while (items_sent < 950) begin
            if ($urandom_range(0, 99) < 6) begin
                idle_on = ~idle_on;
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, MAX_POSITION + 1)
                                              : $urandom_range(10, 30);
            if ($urandom_range(0, 15) == 0) begin
                len = MAX_POSITION + 1;
            end
            cmd  = any_reply_cmd();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_frame(cmd, len, len, 1'b0, 1'b1);
            end else if (pick < 53) begin
                // Any other command word.
                send_frame(16'($urandom_range(0, 16'hFFFF)), len, len, 1'b0, 1'b1);
            end else if (pick < 63) begin
                send_frame(cmd, len, len, 1'b1, 1'b1);
            end else if (pick < 70) begin
                // Too short to be a frame.
                send_frame(cmd, $urandom_range(0, 9), 8, 1'b0, 1'b1);
            end else if (pick < 76) begin
                // Longer than the receiver can hold: it stays open until the next start.
                len = ($urandom_range(0, 1) == 0) ? $urandom_range(MAX_POSITION + 2, 70)
                                                  : $urandom_range(MAX_POSITION + 2, 65535);
                send_frame(cmd, len, $urandom_range(8, 80), 1'b0, 1'b1);
            end else if (pick < 84) begin
                // Cut short; whatever follows either restarts it or runs on in it.
                send_frame(cmd, len, $urandom_range(2, len - 1), 1'b0, 1'b1);
            end else if (pick < 91) begin
                put_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    put_item(OP_BYTE, ($urandom_range(0, 2) == 0) ? START_A
                                                                 : 8'($urandom_range(0, 255)));
                end
            end
        end
        s_valid <= 1'b0;

        // Drain the outstanding results, then keep watching for strays before the verdict.
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
src/ccrfr_pkg.sv
src/crc_checked_reply_frame_receiver.sv
src/ccrfr_checker.sv
bench/reply_frame_checker.sv
bench/tb_top.sv
